/* sv/dag_pkg.sv */
// ----------------------------------------------------------------------------
// Distance attenuation gain package
// Widths, register indexes, model codes and the log2 and exp2 tables.
// ----------------------------------------------------------------------------
package dag_pkg;

	localparam int LOG_TABLE_BITS = 8;
	localparam int TBL_N          = 1 << LOG_TABLE_BITS;
	localparam int LOG_SH         = 31 - LOG_TABLE_BITS;
	localparam int EXP_SH         = 24 - LOG_TABLE_BITS;
	localparam int LOG_VAL_W      = 25;

	localparam int DIST_W     = 32;
	localparam int GAIN_W     = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	// Divider operand widths.
	localparam int NUM_W  = 56;
	localparam int DEN_W  = 49;
	localparam int CMP_W  = DEN_W + GAIN_W;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 20'h10000;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 20'hFFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE    = 3'd0,
		REG_REF     = 3'd1,
		REG_MAX     = 3'd2,
		REG_ROLLOFF = 3'd3,
		REG_AIR     = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		MODE_NONE      = 4'd0,
		MODE_INV_EXP   = 4'd1,
		MODE_AIR       = 4'd2,
		MODE_INV       = 4'd3,
		MODE_INV_CLAMP = 4'd4,
		MODE_LIN       = 4'd5,
		MODE_LIN_CLAMP = 4'd6,
		MODE_EXP       = 4'd7,
		MODE_EXP_CLAMP = 4'd8
	} model_mode_t;

	typedef struct packed {
		logic dcz;   // clamped distance is zero
		logic dz;    // denominator is zero
		logic dneg;  // denominator is negative
		logic qneg;  // quotient is negative
		logic ovf;   // quotient does not fit the gain width
	} div_ctl_t;

	typedef logic [LOG_VAL_W-1:0] log_tbl_t [TBL_N+1];
	typedef logic [31:0] exp_tbl_t [TBL_N+1];

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x = v;
		res = '0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 64'd0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// log2(1 + i/N) in Q.24, by repeated squaring.
	function automatic log_tbl_t build_log_tbl();
		log_tbl_t t;
		logic [63:0] y;
		logic [LOG_VAL_W-1:0] r;
		for (int i = 0; i < TBL_N; i++) begin
			y = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
			r = '0;
			for (int k = 0; k < 24; k++) begin
				y = (y * y) >> 30;
				r = r << 1;
				if (y >= (64'd1 << 31)) begin
					r[0] = 1'b1;
					y = y >> 1;
				end
			end
			t[i] = r;
		end
		t[TBL_N] = LOG_VAL_W'(1) << 24;
		return t;
	endfunction

	// 2^(i/N) in Q30, as a product of repeated square roots of two.
	function automatic exp_tbl_t build_exp_tbl();
		exp_tbl_t t;
		logic [63:0] roots [LOG_TABLE_BITS+1];
		logic [63:0] m;
		roots[0] = 64'd1 << 31;
		for (int k = 1; k <= LOG_TABLE_BITS; k++) roots[k] = isqrt64(roots[k-1] << 30);
		for (int i = 0; i < TBL_N; i++) begin
			m = 64'd1 << 30;
			for (int k = 0; k < LOG_TABLE_BITS; k++) begin
				if (((i >> k) & 1) != 0) m = (m * roots[LOG_TABLE_BITS - k]) >> 30;
			end
			t[i] = 32'(m);
		end
		t[TBL_N] = 32'h8000_0000;
		return t;
	endfunction

	localparam log_tbl_t LOG_TBL = build_log_tbl();
	localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

/* sv/distance_attenuation_gain_top.sv */
// ----------------------------------------------------------------------------
// Distance attenuation gain
// Turns a source distance into a linear gain under the selected model.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[31:0] distance, Q16.16
//  m_axis    out        tdata[19:0] gain, Q4.16
//  cfg       in         cfg_idx selects the register, cfg_wdata the value
//
// An item passes 27 pipeline stages, 20 of them one quotient bit each of the
// restoring divider, then the output register. One item is taken in every
// cycle while the skid register is empty.
// Reset clears the valid bits and the registers to their reset values.
// A stalled output freezes the pipeline once the skid register is full.
// ----------------------------------------------------------------------------
module distance_attenuation_gain_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [dag_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] distance
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [dag_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [19:0] gain
	input  logic                            cfg_we,
	input  logic [dag_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [dag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import dag_pkg::*;

	localparam int DIV0  = 7;
	localparam int NSTG  = DIV0 + GAIN_W;
	localparam int XG_N  = DIV0 + GAIN_W - 10;
	localparam logic signed [39:0] E_HI  = 40'sd67108864;    // 4.0
	localparam logic signed [39:0] E_LO  = -40'sd285212672;  // -17.0
	localparam logic signed [39:0] E_OFS = 40'sd285212672;

	function automatic logic [4:0] msb_pos(input logic [31:0] x);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) p = 5'(i);
		end
		return p;
	endfunction

	// Configuration registers.
	logic [3:0]        mode_q;
	logic [DIST_W-1:0] ref_q;
	logic [DIST_W-1:0] max_q;
	logic [15:0]       roll_q;
	logic [23:0]       air_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			ref_q  <= 32'h0001_0000;
			max_q  <= 32'hFFFF_FFFF;
			roll_q <= 16'h0100;
			air_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:    mode_q <= cfg_wdata[3:0];
				REG_REF:     ref_q  <= cfg_wdata[DIST_W-1:0];
				REG_MAX:     max_q  <= cfg_wdata[DIST_W-1:0];
				REG_ROLLOFF: roll_q <= cfg_wdata[15:0];
				REG_AIR:     air_q  <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// Flow control.
	logic            ce;
	logic [NSTG:1]   vld_s;
	logic            out_v_q, skid_v_q;
	logic [GAIN_W-1:0] out_q, skid_q;
	logic            leave;

	assign ce = !skid_v_q;
	assign s_axis_tready = ce;
	assign leave = ce && vld_s[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[NSTG-1:1], s_axis_tvalid};
		end
	end

	// Stage registers.
	logic [DIST_W-1:0]    d_s1, dc_s2;
	logic [31:0]          xa_s3, xb_s3, excess_s3;
	logic [4:0]           pa_s3, pb_s3, pa_s4, pb_s4;
	logic signed [32:0]   diff_s3;
	logic                 dcz_s3, dcz_s4;
	logic [LOG_VAL_W-1:0] loa_s4, dla_s4, lob_s4, dlb_s4;
	logic [LOG_SH-1:0]    rema_s4, remb_s4;
	logic [55:0]          p1_s4, p2_s5;
	logic signed [49:0]   dprod_s4;
	logic signed [29:0]   la_s5, lb_s5;
	logic [NUM_W-1:0]     n_s5, n_s6;
	logic [DEN_W-1:0]     dd_s5, dd_s6;
	div_ctl_t             ctl_s5, ctl_s6;
	logic signed [30:0]   l_s6;
	logic [32:0]          db_s6;
	logic signed [39:0]   e_s7;
	logic [31:0]          xlo_s8, xdl_s8;
	logic [EXP_SH-1:0]    xrem_s8;
	logic [4:0]           xsh_s8, xsh_s9;
	logic                 xhi_s8, xlo0_s8, xhi_s9, xlo0_s9;
	logic [32:0]          xm_s9;
	logic [GAIN_W-1:0]    xg_s [XG_N];
	logic [NUM_W-1:0]     rem_s [GAIN_W];
	logic [DEN_W-1:0]     den_s [GAIN_W];
	logic [GAIN_W-1:0]    quo_s [GAIN_W];
	div_ctl_t             ctl_s [GAIN_W];
	logic [GAIN_W-1:0]    gain_sfin;

	// Combinational values of each stage.
	logic [31:0]          dcl, dmx, xa, xb;
	logic [31:0]          ma, mb;
	logic [LOG_TABLE_BITS:0] ia0, ia1, ib0, ib1;
	logic [23:0]          amag;
	logic [LOG_VAL_W+LOG_SH-1:0] pra, prb;
	logic [LOG_VAL_W-1:0] vala, valb;
	logic [49:0]          dmag;
	logic signed [50:0]   iden;
	logic signed [32:0]   lden;
	logic                 is_lin;
	div_ctl_t             ctl_n;
	logic [29:0]          al;
	logic [45:0]          pm;
	logic [62:0]          exprod;
	logic signed [39:0]   e_pow, e_air, u;
	logic [LOG_TABLE_BITS:0] ie0, ie1;
	logic [31+EXP_SH:0]   xpr;
	logic [33:0]          rsum;
	logic [33:0]          gsh;
	logic [GAIN_W-1:0]    xg_d;

	always_comb begin
		// S2: clamp to [reference, maximum] in the clamping modes.
		dmx = (d_s1 < ref_q) ? ref_q : d_s1;
		dmx = (dmx > max_q) ? max_q : dmx;
		dcl = (mode_q == MODE_INV_CLAMP || mode_q == MODE_LIN_CLAMP ||
			mode_q == MODE_EXP_CLAMP) ? dmx : d_s1;

		// S3: log operands, floored at 1.0 for the inverse exponent model.
		if (mode_q == MODE_INV_EXP) begin
			xa = (dc_s2 < 32'h0001_0000) ? 32'h0001_0000 : dc_s2;
			xb = (ref_q < 32'h0001_0000) ? 32'h0001_0000 : ref_q;
		end else begin
			xa = dc_s2;
			xb = ref_q;
		end

		// S4: normalise and look up.
		ma = xa_s3 << (5'd31 - pa_s3);
		mb = xb_s3 << (5'd31 - pb_s3);
		ia0 = {1'b0, ma[30 -: LOG_TABLE_BITS]};
		ia1 = ia0 + 1'b1;
		ib0 = {1'b0, mb[30 -: LOG_TABLE_BITS]};
		ib1 = ib0 + 1'b1;
		amag = air_q[23] ? 24'(-air_q) : air_q;

		// S5: interpolate the logs; set up the division.
		pra = dla_s4 * rema_s4;
		prb = dlb_s4 * remb_s4;
		vala = loa_s4 + LOG_VAL_W'(pra >> LOG_SH);
		valb = lob_s4 + LOG_VAL_W'(prb >> LOG_SH);
		dmag = dprod_s4[49] ? 50'(-dprod_s4) : 50'(dprod_s4);
		iden = $signed({11'b0, ref_q, 8'b0}) + $signed({dprod_s4[49], dprod_s4});
		lden = $signed({1'b0, max_q}) - $signed({1'b0, ref_q});
		is_lin = (mode_q == MODE_LIN || mode_q == MODE_LIN_CLAMP);

		// S6: flag a quotient too large for the gain width.
		ctl_n = ctl_s5;
		ctl_n.ovf = {{(CMP_W-NUM_W){1'b0}}, n_s5} >= {dd_s5, {GAIN_W{1'b0}}};

		// S7: exponent for exp2.
		al = l_s6[30] ? 30'(-l_s6) : l_s6[29:0];
		pm = al * roll_q;
		e_pow = l_s6[30] ? $signed({2'b0, pm[45:8]}) : -$signed({2'b0, pm[45:8]});
		exprod = db_s6 * 30'd713378626;
		e_air = air_q[23] ? -$signed({9'b0, exprod[62:32]}) : $signed({9'b0, exprod[62:32]});

		// S8: split the exponent into integer and fraction.
		u = e_s7 + E_OFS;
		ie0 = {1'b0, u[23 -: LOG_TABLE_BITS]};
		ie1 = ie0 + 1'b1;

		// S9 and S10: interpolate, then round to the Q4.16 step.
		xpr = xdl_s8 * xrem_s8;
		rsum = {1'b0, xm_s9} + (34'd1 << (xsh_s9 - 5'd1));
		gsh = rsum >> xsh_s9;
		if (xhi_s9) begin
			xg_d = GAIN_MAX;
		end else if (xlo0_s9) begin
			xg_d = '0;
		end else if (gsh > 34'(GAIN_MAX)) begin
			xg_d = GAIN_MAX;
		end else begin
			xg_d = gsh[GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			d_s1      <= s_axis_tdata[DIST_W-1:0];
			dc_s2     <= dcl;
			xa_s3     <= xa;
			xb_s3     <= xb;
			pa_s3     <= msb_pos(xa);
			pb_s3     <= msb_pos(xb);
			excess_s3 <= (dc_s2 > ref_q) ? dc_s2 - ref_q : '0;
			diff_s3   <= $signed({1'b0, dc_s2}) - $signed({1'b0, ref_q});
			dcz_s3    <= (dc_s2 == '0);

			loa_s4   <= LOG_TBL[ia0];
			dla_s4   <= LOG_TBL[ia1] - LOG_TBL[ia0];
			rema_s4  <= ma[LOG_SH-1:0];
			lob_s4   <= LOG_TBL[ib0];
			dlb_s4   <= LOG_TBL[ib1] - LOG_TBL[ib0];
			remb_s4  <= mb[LOG_SH-1:0];
			pa_s4    <= pa_s3;
			pb_s4    <= pb_s3;
			p1_s4    <= excess_s3 * amag;
			dprod_s4 <= diff_s3 * $signed({1'b0, roll_q});
			dcz_s4   <= dcz_s3;

			la_s5 <= $signed({1'b0, pa_s4, 24'b0}) - 30'sh1000_0000 + $signed({5'b0, vala});
			lb_s5 <= $signed({1'b0, pb_s4, 24'b0}) - 30'sh1000_0000 + $signed({5'b0, valb});
			p2_s5 <= p1_s4[55:16] * roll_q;
			ctl_s5.dcz <= dcz_s4;
			ctl_s5.ovf <= 1'b0;
			if (is_lin) begin
				n_s5 <= {dmag[47:0], 8'b0};
				dd_s5 <= DEN_W'(lden[32] ? 33'(-lden) : 33'(lden));
				ctl_s5.dz <= (lden == '0);
				ctl_s5.dneg <= 1'b0;
				ctl_s5.qneg <= dprod_s4[49] ^ lden[32];
			end else begin
				n_s5 <= {ref_q, 24'b0};
				dd_s5 <= iden[DEN_W-1:0];
				ctl_s5.dz <= (iden == '0);
				ctl_s5.dneg <= iden[50];
				ctl_s5.qneg <= 1'b0;
			end

			l_s6  <= $signed({la_s5[29], la_s5}) - $signed({lb_s5[29], lb_s5});
			db_s6 <= (p2_s5 > 56'h1_0000_0000) ? 33'h1_0000_0000 : p2_s5[32:0];
			n_s6  <= n_s5;
			dd_s6 <= dd_s5;
			ctl_s6 <= ctl_n;

			e_s7 <= (mode_q == MODE_AIR) ? e_air : e_pow;

			xhi_s8  <= (e_s7 >= E_HI);
			xlo0_s8 <= (e_s7 < E_LO);
			xlo_s8  <= EXP_TBL[ie0];
			xdl_s8  <= EXP_TBL[ie1] - EXP_TBL[ie0];
			xrem_s8 <= u[EXP_SH-1:0];
			xsh_s8  <= 5'd31 - u[28:24];

			xm_s9   <= {1'b0, xlo_s8} + 33'(xpr >> EXP_SH);
			xsh_s9  <= xsh_s8;
			xhi_s9  <= xhi_s8;
			xlo0_s9 <= xlo0_s8;

			xg_s[0] <= xg_d;
			for (int k = 1; k < XG_N; k++) xg_s[k] <= xg_s[k-1];
		end
	end

	// Restoring divider, one quotient bit per stage, most significant first.
	for (genvar j = 0; j < GAIN_W; j++) begin : g_div
		localparam int B = GAIN_W - 1 - j;
		logic [NUM_W-1:0]  rem_p;
		logic [DEN_W-1:0]  den_p;
		logic [GAIN_W-1:0] quo_p;
		div_ctl_t          ctl_p;
		logic [CMP_W-1:0]  sub_w;
		logic              take;
		if (j == 0) begin : g_first
			assign rem_p = n_s6;
			assign den_p = dd_s6;
			assign quo_p = '0;
			assign ctl_p = ctl_s6;
		end else begin : g_next
			assign rem_p = rem_s[j-1];
			assign den_p = den_s[j-1];
			assign quo_p = quo_s[j-1];
			assign ctl_p = ctl_s[j-1];
		end
		assign sub_w = CMP_W'(den_p) << B;
		assign take  = CMP_W'(rem_p) >= sub_w;
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[j] <= take ? NUM_W'(CMP_W'(rem_p) - sub_w) : rem_p;
				den_s[j] <= den_p;
				quo_s[j] <= quo_p | (GAIN_W'(take) << B);
				ctl_s[j] <= ctl_p;
			end
		end
	end

	// Final stage: pick the result for the model.
	div_ctl_t          fc;
	logic [GAIN_W-1:0] fq, inv_g, lin_g, fin_g;
	logic [GAIN_W:0]   lsum;

	always_comb begin
		fc = ctl_s[GAIN_W-1];
		fq = quo_s[GAIN_W-1];
		lsum = {1'b0, fq} + {1'b0, GAIN_ONE};
		if (fc.dz) begin
			inv_g = GAIN_ONE;
		end else if (fc.dneg) begin
			inv_g = '0;
		end else if (fc.ovf) begin
			inv_g = GAIN_MAX;
		end else begin
			inv_g = fq;
		end
		if (fc.dz) begin
			lin_g = GAIN_ONE;
		end else if (fc.ovf) begin
			lin_g = fc.qneg ? GAIN_MAX : '0;
		end else if (fc.qneg) begin
			lin_g = lsum[GAIN_W] ? GAIN_MAX : lsum[GAIN_W-1:0];
		end else begin
			lin_g = (fq >= GAIN_ONE) ? '0 : GAIN_ONE - fq;
		end
		unique case (mode_q) inside
			MODE_INV_EXP:                   fin_g = (ref_q == '0) ? GAIN_ONE : xg_s[XG_N-1];
			MODE_AIR:                       fin_g = xg_s[XG_N-1];
			MODE_INV, MODE_INV_CLAMP:       fin_g = inv_g;
			MODE_LIN, MODE_LIN_CLAMP:       fin_g = lin_g;
			MODE_EXP, MODE_EXP_CLAMP:
				fin_g = (ref_q == '0 || fc.dcz) ? GAIN_ONE : xg_s[XG_N-1];
			default:                        fin_g = GAIN_ONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			gain_sfin <= fin_g;
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= leave;
			end
		end else if (leave) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_q <= skid_v_q ? skid_q : gain_sfin;
		end else if (leave) begin
			skid_q <= gain_sfin;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-GAIN_W){1'b0}}, out_q};

	// A waiting item in the skid register always has one in front of it.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	// An item leaving the pipeline into a stalled output must land in the skid.
	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NSTG] && !skid_v_q && out_v_q && !m_axis_tready) |=> skid_v_q)
		else $error("item lost at stalled output");

	// A zero denominator in a dividing model gives unity gain.
	a_den_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		(ce && vld_s[NSTG-1] && ctl_s[GAIN_W-1].dz &&
		(mode_q == MODE_INV || mode_q == MODE_INV_CLAMP ||
		mode_q == MODE_LIN || mode_q == MODE_LIN_CLAMP)) |=> (gain_sfin == GAIN_ONE))
		else $error("zero denominator did not give unity gain");

endmodule

/* tb/dag_gain_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Distance attenuation gain checker
// Watches the register port and both streams, predicts the gain of every
// accepted distance and compares it in order with the gains that come out.
// ----------------------------------------------------------------------------
module dag_gain_checker
	import dag_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output int                     fail_count,
	output int                     pending
);

	localparam longint Q24 = 64'sd16777216;
	localparam int NPTS = 1 << LOG_TABLE_BITS;

	logic [3:0]  cur_mode;
	logic [31:0] cur_ref;
	logic [31:0] cur_max;
	logic [15:0] cur_roll;
	logic [23:0] cur_air;

	longint unsigned log2_pts [NPTS+1];
	longint unsigned exp2_pts [NPTS+1];
	logic [GAIN_W-1:0] gains_due [$];
	int n_checked;

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	initial begin
		longint unsigned roots [LOG_TABLE_BITS+1];
		longint unsigned y, r, m;
		roots[0] = 64'd1 << 31;
		for (int k = 1; k <= LOG_TABLE_BITS; k++) roots[k] = int_sqrt(roots[k-1] << 30);
		for (int i = 0; i < NPTS; i++) begin
			y = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
			r = 0;
			for (int k = 0; k < 24; k++) begin
				y = (y * y) >> 30;
				r = r << 1;
				if (y >= (64'd1 << 31)) begin
					r = r | 1;
					y = y >> 1;
				end
			end
			log2_pts[i] = r;
			m = 64'd1 << 30;
			for (int k = 0; k < LOG_TABLE_BITS; k++)
				if (((i >> k) & 1) != 0) m = (m * roots[LOG_TABLE_BITS - k]) >> 30;
			exp2_pts[i] = m;
		end
		log2_pts[NPTS] = 64'd1 << 24;
		exp2_pts[NPTS] = 64'd1 << 31;
	end

	function automatic longint log2_fix(input logic [31:0] x);
		int p;
		longint unsigned f, idx, rem, val;
		p = 31;
		while (p > 0 && !x[p]) p--;
		f = (64'(x) << (31 - p)) - (64'd1 << 31);
		idx = f >> (31 - LOG_TABLE_BITS);
		rem = f & ((64'd1 << (31 - LOG_TABLE_BITS)) - 1);
		val = log2_pts[idx] +
			(((log2_pts[idx+1] - log2_pts[idx]) * rem) >> (31 - LOG_TABLE_BITS));
		return longint'(p - 16) * Q24 + longint'(val);
	endfunction

	function automatic logic [GAIN_W-1:0] exp2_gain(input longint e);
		longint unsigned u, ip, frac, idx, rem, m, g;
		int s;
		if (e >= 4 * Q24) return GAIN_MAX;
		if (e < -17 * Q24) return '0;
		u = longint'(e + 17 * Q24);
		ip = u >> 24;
		frac = u & 64'hFFFFFF;
		idx = frac >> (24 - LOG_TABLE_BITS);
		rem = frac & ((64'd1 << (24 - LOG_TABLE_BITS)) - 1);
		m = exp2_pts[idx] +
			(((exp2_pts[idx+1] - exp2_pts[idx]) * rem) >> (24 - LOG_TABLE_BITS));
		s = 31 - int'(ip);
		g = (m + (64'd1 << (s - 1))) >> s;
		return (g > 64'(GAIN_MAX)) ? GAIN_MAX : g[GAIN_W-1:0];
	endfunction

	// Power with a negated, rolloff-scaled exponent; magnitude truncated.
	function automatic logic [GAIN_W-1:0] power_gain(input longint l);
		longint unsigned mag;
		if (l >= 0) begin
			mag = (longint'(l) * 64'(cur_roll)) >> 8;
			return exp2_gain(-longint'(mag));
		end
		mag = (longint'(-l) * 64'(cur_roll)) >> 8;
		return exp2_gain(longint'(mag));
	endfunction

	function automatic logic [GAIN_W-1:0] clip_gain(input longint g);
		if (g < 0) return '0;
		if (g > longint'(GAIN_MAX)) return GAIN_MAX;
		return g[GAIN_W-1:0];
	endfunction

	function automatic logic [GAIN_W-1:0] predict_gain(input logic [31:0] dist_in);
		logic [31:0] d, dd, rr;
		longint a, den, num;
		longint unsigned excess, amag, db, ex;
		d = dist_in;
		if (cur_mode == MODE_INV_CLAMP || cur_mode == MODE_LIN_CLAMP ||
				cur_mode == MODE_EXP_CLAMP) begin
			if (d < cur_ref) d = cur_ref;
			if (d > cur_max) d = cur_max;
		end
		case (cur_mode)
			MODE_INV_EXP: begin
				dd = (d < 32'(GAIN_ONE)) ? 32'(GAIN_ONE) : d;
				rr = (cur_ref < 32'(GAIN_ONE)) ? 32'(GAIN_ONE) : cur_ref;
				if (cur_ref == 0) return GAIN_ONE;
				return power_gain(log2_fix(dd) - log2_fix(rr));
			end
			MODE_AIR: begin
				excess = (d > cur_ref) ? 64'(d - cur_ref) : 0;
				a = longint'(signed'(cur_air));
				amag = (a < 0) ? -a : a;
				db = ((excess * amag) >> 16) * 64'(cur_roll);
				if (db > (64'd1 << 32)) db = 64'd1 << 32;
				ex = (db * 64'd713378626) >> 32;
				return exp2_gain((a < 0) ? -longint'(ex) : longint'(ex));
			end
			MODE_INV, MODE_INV_CLAMP: begin
				den = longint'(cur_ref) * 256 +
					(longint'(d) - longint'(cur_ref)) * longint'(cur_roll);
				if (den == 0) return GAIN_ONE;
				if (den < 0) return '0;
				return clip_gain(longint'((64'(cur_ref) << 24) / 64'(den)));
			end
			MODE_LIN, MODE_LIN_CLAMP: begin
				den = longint'(cur_max) - longint'(cur_ref);
				if (den == 0) return GAIN_ONE;
				num = (longint'(d) - longint'(cur_ref)) * longint'(cur_roll) * 256;
				return clip_gain(longint'(GAIN_ONE) - num / den);
			end
			MODE_EXP, MODE_EXP_CLAMP: begin
				if (cur_ref == 0 || d == 0) return GAIN_ONE;
				return power_gain(log2_fix(d) - log2_fix(cur_ref));
			end
			default: return GAIN_ONE;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode <= MODE_NONE;
			cur_ref  <= 32'h0001_0000;
			cur_max  <= 32'hFFFF_FFFF;
			cur_roll <= 16'd256;
			cur_air  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_MODE:    cur_mode <= cfg_wdata[3:0];
				REG_REF:     cur_ref  <= cfg_wdata;
				REG_MAX:     cur_max  <= cfg_wdata;
				REG_ROLLOFF: cur_roll <= cfg_wdata[15:0];
				REG_AIR:     cur_air  <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	initial begin
		fail_count = 0;
		pending = 0;
		n_checked = 0;
	end

	always @(posedge clk) begin
		logic [GAIN_W-1:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready) gains_due.push_back(predict_gain(s_tdata[31:0]));
			if (m_tvalid && m_tready) begin
				if (gains_due.size() == 0) begin
					$error("gain item %0h arrived with none outstanding", m_tdata[GAIN_W-1:0]);
					fail_count++;
				end else begin
					want = gains_due.pop_front();
					n_checked++;
					if (m_tdata[GAIN_W-1:0] !== want) begin
						$error("gain: expected %0h, got %0h", want, m_tdata[GAIN_W-1:0]);
						fail_count++;
					end
				end
			end
			pending = gains_due.size();
		end
	end

endmodule

/* tb/tb_distance_attenuation_gain_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Distance attenuation gain testbench
// Sweeps every model and unused mode codes through directed and random
// register settings, streams distances in bursts against a stalling sink.
// ----------------------------------------------------------------------------
module tb_distance_attenuation_gain_top;
	import dag_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int fail_count;
	int pending;
	int cycles;
	int burst_left;
	int n_sent;
	int n_settings;
	logic [31:0] ref_now;
	logic [31:0] max_now;

	distance_attenuation_gain_top i_dut (.*);

	dag_gain_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("distance_attenuation_gain_top: mismatch");
			$finish;
		end
	end

	// The sink stalls on its own pattern, changing character every so often.
	always @(negedge clk) begin
		case ((cycles / 300) % 4)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(1, 0) == 1);
			2: m_axis_tready <= ($urandom_range(3, 0) == 0);
			default: m_axis_tready <= ($urandom_range(7, 0) != 0);
		endcase
	end

	task automatic send_distance(input logic [31:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(6, 0);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(12, 1);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		n_sent++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	// Registers change only with the pipeline empty.
	task automatic set_model(input logic [3:0] mode, input logic [31:0] rd,
			input logic [31:0] md, input logic [15:0] roll, input logic [23:0] air);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		write_reg(REG_MODE, 32'(mode));
		write_reg(REG_REF, rd);
		write_reg(REG_MAX, md);
		write_reg(REG_ROLLOFF, 32'(roll));
		write_reg(REG_AIR, 32'(air));
		cfg_we <= 1'b0;
		ref_now = rd;
		max_now = md;
		n_settings++;
	endtask

	function automatic logic [31:0] pick_distance();
		case ($urandom_range(9, 0))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return ref_now;
			3: return max_now;
			4: return ref_now + $urandom_range(3, 0) - 1;
			5: return ref_now + $urandom_range(32'h000F_FFFF, 0);
			6: return $urandom_range(32'h0010_0000, 0);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_length();
		case ($urandom_range(6, 0))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0001_0000;
			3: return $urandom_range(32'h000F_FFFF, 0);
			default: return $urandom_range(32'h0040_0000, 1);
		endcase
	endfunction

	initial begin
		logic [3:0] mode;
		logic [31:0] rd, md;
		logic [15:0] roll;
		logic [23:0] air;
		cycles = 0;
		burst_left = 0;
		n_sent = 0;
		n_settings = 0;
		ref_now = 32'h0001_0000;
		max_now = 32'hFFFF_FFFF;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MODE;
		cfg_wdata = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings first, then every model at a plain setting.
		send_distance(32'h0);
		send_distance(32'hFFFF_FFFF);
		for (int m = MODE_INV_EXP; m <= MODE_EXP_CLAMP; m++) begin
			set_model(4'(m), 32'h0001_0000, 32'h0010_0000, 16'h0100, 24'hFF0000);
			send_distance(32'h0);
			send_distance(32'h0003_0000);
			send_distance(32'hFFFF_FFFF);
		end

		while (n_sent < 720) begin
			mode = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 9))
				: 4'($urandom_range(8, 1));
			rd = pick_length();
			md = ($urandom_range(3, 0) == 0) ? pick_length() : rd + pick_length();
			case ($urandom_range(5, 0))
				0: roll = 16'h0;
				1: roll = 16'hFFFF;
				2: roll = 16'h0100;
				default: roll = 16'($urandom_range(16'h0400, 1));
			endcase
			case ($urandom_range(5, 0))
				0: air = 24'h7F_FFFF;
				1: air = 24'h80_0000;
				2: air = 24'($urandom);
				default: air = 24'($signed($urandom_range(32'h0006_0000, 0)) - 32'sh3_0000);
			endcase
			set_model(mode, rd, md, roll, air);
			repeat ($urandom_range(48, 16)) send_distance(pick_distance());
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d distances over %0d register settings, all models and unused codes.",
			n_sent, n_settings);
		if (fail_count == 0 && pending == 0) begin
			$display("distance_attenuation_gain_top: match");
		end else begin
			$display("distance_attenuation_gain_top: mismatch");
		end
		$finish;
	end

endmodule
